FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the terminal writer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define TTCW_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define TTCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ttcw_pkg.sv
// Package for the text terminal cursor writer: screen geometry, field widths,
// control codes and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package ttcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;

	// Field widths
	localparam int CODE_W = 8;
	localparam int ATTR_W = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int IDX_W  = 11;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [ATTR_W-1:0] ATTR_RESET = ATTR_W'(7);

	// Character codes
	localparam logic [CODE_W-1:0] CODE_BEL   = 8'd7;
	localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
	localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
	localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
	localparam logic [CODE_W-1:0] CODE_FF    = 8'd12;
	localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
	localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} cursor_t;

	typedef struct packed {
		logic              write_enable;
		logic [IDX_W-1:0]  cell_index;
		logic [CODE_W-1:0] cell_char;
		logic [ATTR_W-1:0] cell_attribute;
		logic              beep;
		cursor_t           cursor;
	} result_t;

endpackage

FILE: hw/rtl/text_terminal_cursor_writer_core.sv
// Top level of the text terminal cursor writer: input register, cursor state,
// attribute register and result stage. Depends on ttcw_pkg, ttcw_step,
// ttcw_result_reg and assert_macros.svh.
//
//  channel | signals                              | direction
//  cfg     | cfg_valid, cfg_ready, cfg_data       | in (attribute write)
//  in      | in_valid, in_ready, char_code        | in (one character)
//  out     | out_valid, out_ready, result fields  | out (one per character)
//
// One character per cycle unless stalled; registers: input, then result.
// The cursor register is updated in the same cycle the result register loads,
// so a following character sees the new cursor with no bubble.
// Reset puts the cursor at (0,0) and the attribute at 7.
// A stalled output holds the result and backs up into the input register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_terminal_cursor_writer_core
	import ttcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ATTR_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CODE_W-1:0] char_code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              write_enable,
	output logic [IDX_W-1:0]  cell_index,
	output logic [CODE_W-1:0] cell_char,
	output logic [ATTR_W-1:0] cell_attribute,
	output logic              beep,
	output logic [COL_W-1:0]  cursor_column,
	output logic [ROW_W-1:0]  cursor_row
);

	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;
	logic [ATTR_W-1:0] attr_q;
	cursor_t           cursor_q;
	cursor_t           cursor_nxt;
	result_t           step_res;
	result_t           out_res;
	logic              room;
	logic              take;

	// Attribute register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	// Input register
	assign take     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= char_code;
		end
	end

	// Character decode and cursor move
	ttcw_step u_step (
		.code (code_s1),
		.cur  (cursor_q),
		.attr (attr_q),
		.nxt  (cursor_nxt),
		.res  (step_res)
	);

	// Cursor advances when its request moves into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (take) begin
			cursor_q <= cursor_nxt;
		end
	end

	ttcw_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (step_res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign write_enable   = out_res.write_enable;
	assign cell_index     = out_res.cell_index;
	assign cell_char      = out_res.cell_char;
	assign cell_attribute = out_res.cell_attribute;
	assign beep           = out_res.beep;
	assign cursor_column  = out_res.cursor.col;
	assign cursor_row     = out_res.cursor.row;

	// Checks
	`TTCW_ASSERT_ALWAYS(a_cursor_range, clk, arst_n, (cursor_q.col <= COL_LAST) && (cursor_q.row <= ROW_LAST), "cursor outside screen")
	`TTCW_ASSERT_ALWAYS(a_index_range, clk, arst_n, !(out_valid && write_enable) || (cell_index < IDX_W'(COLUMNS * ROWS)), "cell index beyond screen")
	`TTCW_ASSERT_NEXT(a_cursor_hold, clk, arst_n, !take, $stable(cursor_q), "cursor moved without a request")
	`TTCW_ASSERT_NEXT(a_out_cursor, clk, arst_n, take, (out_res.cursor == cursor_q), "result cursor differs from state")
	`TTCW_ASSERT_ALWAYS(a_beep_no_write, clk, arst_n, !(out_valid && beep && write_enable), "bell request wrote a cell")

endmodule

FILE: hw/rtl/ttcw_step.sv
// Combinational cursor update and cell write decode for one character.
// Depends on ttcw_pkg.
`timescale 1ns / 1ps

module ttcw_step
	import ttcw_pkg::*;
(
	input  logic [CODE_W-1:0] code,
	input  cursor_t           cur,
	input  logic [ATTR_W-1:0] attr,
	output cursor_t           nxt,
	output result_t           res
);

	logic [ROW_W-1:0]   down_row;
	logic [4:0]         tab_grp;
	logic [7:0]         tab_col;
	logic               we;
	logic               bell;
	logic [CODE_W-1:0]  ch;
	cursor_t            wr;
	logic [IDX_W-1:0]   idx_full;

	// Row below with clamp at the bottom
	assign down_row = (cur.row >= ROW_LAST) ? ROW_LAST : cur.row + ROW_W'(1);

	// Next tab stop, one bit wider so it can be compared against the width
	assign tab_grp = {1'b0, cur.col[COL_W-1:3]} + 5'd1;
	assign tab_col = {tab_grp, 3'b000};

	// Cursor move and write decision
	always_comb begin
		nxt  = cur;
		we   = 1'b0;
		bell = 1'b0;
		ch   = CODE_SPACE;
		wr   = cur;
		if (code >= CODE_SPACE) begin
			we = 1'b1;
			ch = code;
			if (cur.col >= COL_LAST) begin
				nxt.col = '0;
				nxt.row = down_row;
			end else begin
				nxt.col = cur.col + COL_W'(1);
			end
		end else begin
			unique case (code)
				CODE_LF: begin
					nxt.row = down_row;
				end
				CODE_CR: begin
					nxt.col = '0;
				end
				CODE_TAB: begin
					if (tab_col >= 8'(COLUMNS)) begin
						nxt.col = '0;
						nxt.row = down_row;
					end else begin
						nxt.col = tab_col[COL_W-1:0];
					end
				end
				CODE_BS: begin
					// Step back; at column 0 wrap to the end of the row above
					if (cur.col != '0) begin
						nxt.col = cur.col - COL_W'(1);
						we      = 1'b1;
					end else if (cur.row != '0) begin
						nxt.row = cur.row - ROW_W'(1);
						nxt.col = COL_LAST;
						we      = 1'b1;
					end
					wr = nxt;
				end
				CODE_FF: begin
					nxt.row = ROW_LAST;
					nxt.col = '0;
				end
				CODE_BEL: begin
					bell = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Linear cell address: row times width plus column (at most 1999)
	assign idx_full = IDX_W'(wr.row) * IDX_W'(COLUMNS) + IDX_W'(wr.col);

	// Unused fields read zero when nothing is written
	always_comb begin
		res.write_enable   = we;
		res.cell_index     = we ? idx_full : '0;
		res.cell_char      = we ? ch : '0;
		res.cell_attribute = we ? attr : '0;
		res.beep           = bell;
		res.cursor         = nxt;
	end

endmodule

FILE: hw/rtl/ttcw_result_reg.sv
// Output register stage with valid/ready toward the consumer.
// Depends on ttcw_pkg.
`timescale 1ns / 1ps

module ttcw_result_reg
	import ttcw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    valid_q;
	result_t data_q;

	// Stage can load when empty or being drained this cycle
	assign room = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (room && push) begin
			data_q <= push_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: sim/ttcw_cursor_checker.sv
// Checker for the text terminal cursor writer: watches the attribute, character
// and result channels, predicts each result and compares it field by field.
// Depends on ttcw_pkg for geometry, field widths, codes and result_t.
`timescale 1ns / 1ps

module ttcw_cursor_checker
	import ttcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [ATTR_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [CODE_W-1:0] char_code,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              write_enable,
	input  logic [IDX_W-1:0]  cell_index,
	input  logic [CODE_W-1:0] cell_char,
	input  logic [ATTR_W-1:0] cell_attribute,
	input  logic              beep,
	input  logic [COL_W-1:0]  cursor_column,
	input  logic [ROW_W-1:0]  cursor_row,
	output int                error_count,
	output int                pending_count
);

	localparam int TAB_STOP = 8;
	localparam int MAX_PRINTED = 20;

	// Predicted cursor and attribute
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ATTR_W-1:0] attr_q;

	result_t expected_cells[$];
	int      errors = 0;

	assign error_count   = errors;
	assign pending_count = expected_cells.size();

	task automatic report_mismatch(input string msg);
		if (errors < MAX_PRINTED)
			$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", what, got, want));
	endtask

	// Row down by one, held at the bottom row (no scrolling)
	function automatic void row_down();
		if (int'(row_q) + 1 < ROWS)
			row_q = row_q + 1'b1;
		else
			row_q = ROW_LAST;
	endfunction

	// Applies one character to the predicted cursor and returns its result
	function automatic result_t put_char(input logic [CODE_W-1:0] code);
		result_t r;
		int      next_stop;
		r = '0;
		if (code >= CODE_SPACE) begin
			r.write_enable   = 1'b1;
			r.cell_index     = IDX_W'(int'(row_q) * COLUMNS + int'(col_q));
			r.cell_char      = code;
			r.cell_attribute = attr_q;
			if (int'(col_q) + 1 >= COLUMNS) begin
				col_q = '0;
				row_down();
			end else begin
				col_q = col_q + 1'b1;
			end
		end else begin
			case (code)
				CODE_LF: row_down();
				CODE_CR: col_q = '0;
				CODE_TAB: begin
					next_stop = (int'(col_q) / TAB_STOP + 1) * TAB_STOP;
					if (next_stop >= COLUMNS) begin
						col_q = '0;
						row_down();
					end else begin
						col_q = COL_W'(next_stop);
					end
				end
				CODE_BS: begin
					// back one cell, across to the row above; nothing at the origin
					if (col_q != '0) begin
						col_q = col_q - 1'b1;
						r.write_enable = 1'b1;
					end else if (row_q != '0) begin
						row_q = row_q - 1'b1;
						col_q = COL_LAST;
						r.write_enable = 1'b1;
					end
					if (r.write_enable) begin
						r.cell_index     = IDX_W'(int'(row_q) * COLUMNS + int'(col_q));
						r.cell_char      = CODE_SPACE;
						r.cell_attribute = attr_q;
					end
				end
				CODE_FF: begin
					row_q = ROW_LAST;
					col_q = '0;
				end
				CODE_BEL: r.beep = 1'b1;
				default: ;
			endcase
		end
		r.cursor.col = col_q;
		r.cursor.row = row_q;
		return r;
	endfunction

	// Compare results first, then log new requests, so a same-edge pair stays in order
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			col_q  = '0;
			row_q  = '0;
			attr_q <= ATTR_RESET;
			expected_cells.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_cells.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_cells.pop_front();
					check_field("write_enable", int'(write_enable), int'(want.write_enable));
					check_field("cell_index", int'(cell_index), int'(want.cell_index));
					check_field("cell_char", int'(cell_char), int'(want.cell_char));
					check_field("cell_attribute", int'(cell_attribute),
						int'(want.cell_attribute));
					check_field("beep", int'(beep), int'(want.beep));
					check_field("cursor_column", int'(cursor_column), int'(want.cursor.col));
					check_field("cursor_row", int'(cursor_row), int'(want.cursor.row));
				end
			end
			if (in_valid && in_ready)
				expected_cells.push_back(put_char(char_code));
			if (cfg_valid && cfg_ready)
				attr_q <= cfg_data;
		end
	end

endmodule

FILE: sim/text_terminal_cursor_writer_core_tb.sv
// Testbench top for text_terminal_cursor_writer_core: clock, reset, character
// and attribute stimulus with random gaps and stalls, and the final verdict.
// Depends on ttcw_pkg, the core RTL and ttcw_cursor_checker.
`timescale 1ns / 1ps

module text_terminal_cursor_writer_core_tb;
	import ttcw_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int PHASE_CHARS   = 275;
	localparam int HOLD_CYCLES   = 150;
	localparam int TAIL_CYCLES   = 8;
	localparam int DIRECTED_LEN  = 25;
	localparam int TABS_TO_WRAP  = 10;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [ATTR_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [CODE_W-1:0] char_code;
	logic              out_valid;
	logic              out_ready;
	logic              write_enable;
	logic [IDX_W-1:0]  cell_index;
	logic [CODE_W-1:0] cell_char;
	logic [ATTR_W-1:0] cell_attribute;
	logic              beep;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;
	int                error_count;
	int                pending_count;

	int cycles       = 0;
	int in_idle_pct  = 12;
	int out_idle_pct = 12;
	int hold_left    = 0;
	int chars_sent   = 0;
	int attr_writes  = 0;

	text_terminal_cursor_writer_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_enable   (write_enable),
		.cell_index     (cell_index),
		.cell_char      (cell_char),
		.cell_attribute (cell_attribute),
		.beep           (beep),
		.cursor_column  (cursor_column),
		.cursor_row     (cursor_row)
	);

	ttcw_cursor_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_enable   (write_enable),
		.cell_index     (cell_index),
		.cell_char      (cell_char),
		.cell_attribute (cell_attribute),
		.beep           (beep),
		.cursor_column  (cursor_column),
		.cursor_row     (cursor_row),
		.error_count    (error_count),
		.pending_count  (pending_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		cycles <= cycles + 1;

	// Watchdog
	initial begin
		wait (cycles >= LIMIT_CYCLES);
		$display("timeout after %0d cycles", cycles);
		$display("[text_terminal_cursor_writer_core] ERROR");
		$finish;
	end

	// Result side: random stalls, plus a counted hold-off when requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	// One character request; starts and ends at a falling edge
	task automatic send_char(input logic [CODE_W-1:0] code);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= code;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0)
			@(negedge clk);
	endtask

	// Attribute write, only while the block is idle
	task automatic write_attr(input logic [ATTR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		attr_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly text with a realistic share of cursor controls, some raw bytes
	function automatic logic [CODE_W-1:0] pick_char();
		int sel;
		sel = $urandom_range(99);
		if (sel < 58)
			return CODE_W'($urandom_range(255, 32));
		else if (sel < 66)
			return CODE_LF;
		else if (sel < 71)
			return CODE_CR;
		else if (sel < 79)
			return CODE_TAB;
		else if (sel < 88)
			return CODE_BS;
		else if (sel < 91)
			return CODE_FF;
		else if (sel < 94)
			return CODE_BEL;
		else
			return CODE_W'($urandom_range(255));
	endfunction

	task automatic random_phase(input int count);
		repeat (count)
			send_char(pick_char());
	endtask

	initial begin
		logic [CODE_W-1:0] directed[DIRECTED_LEN];
		int i;

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		char_code = '0;
		out_ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: backspace at origin, code extremes, each control,
		// bottom-row clamping, backspace across rows, tab wrap on the last row
		directed[0]  = CODE_BS;
		directed[1]  = CODE_SPACE;
		directed[2]  = 8'hFF;
		directed[3]  = CODE_BEL;
		directed[4]  = 8'h00;
		directed[5]  = 8'h1F;
		directed[6]  = 8'h0B;
		directed[7]  = CODE_CR;
		directed[8]  = CODE_TAB;
		directed[9]  = CODE_LF;
		directed[10] = CODE_FF;
		directed[11] = CODE_LF;
		directed[12] = CODE_BS;
		directed[13] = CODE_LF;
		directed[14] = 8'h5A;
		for (i = 0; i < TABS_TO_WRAP; i++)
			directed[15 + i] = CODE_TAB;
		for (i = 0; i < DIRECTED_LEN; i++)
			send_char(directed[i]);
		wait_drain();

		// Attribute at its top value
		write_attr(8'hFF);
		random_phase(PHASE_CHARS);
		wait_drain();

		// Attribute at zero; result side holds off so the input backs up
		write_attr(8'h00);
		hold_left = HOLD_CYCLES;
		random_phase(PHASE_CHARS);
		wait_drain();

		// Random attribute, no idling on either side
		write_attr(ATTR_W'($urandom_range(254, 1)));
		in_idle_pct  = 0;
		out_idle_pct = 0;
		random_phase(PHASE_CHARS);
		wait_drain();

		// Back to the reset attribute with normal idling
		in_idle_pct  = 12;
		out_idle_pct = 12;
		write_attr(ATTR_RESET);
		random_phase(PHASE_CHARS);
		wait_drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d characters sent under %0d attribute settings in %0d cycles,",
			chars_sent, attr_writes + 1, cycles);
		$display("including a long result stall and a run with no idling.");
		if (error_count == 0 && pending_count == 0) begin
			$display("[text_terminal_cursor_writer_core] OK");
		end else begin
			$display("%0d mismatches, %0d results missing", error_count, pending_count);
			$display("[text_terminal_cursor_writer_core] ERROR");
		end
		$finish;
	end

endmodule
